// ===== src/tgtd_pkg.sv =====
`timescale 1ns / 1ps

package tgtd_pkg;

    // Field widths
    localparam int SIZE_W   = 11;
    localparam int RAW_W    = 12;
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 16;
    localparam int COIL_W   = 16;
    localparam int UNIT_W   = 8;
    localparam int BIDX_W   = 3;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_UNIT    = 3'd4;

    localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 11'd320;
    localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 11'd240;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE_MS   = 16'd200;
    localparam logic [COIL_W-1:0] RST_COIL_BASE     = 16'd1001;
    localparam logic [UNIT_W-1:0] RST_SLAVE_UNIT    = 8'd11;

    // Stream payloads
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

endpackage

// ===== src/tgtd_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, two quotient bits per cycle.
module tgtd_div
#(
    parameter int DVD_W = 23,
    parameter int DVS_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEPS = (DVD_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] work_reg, work_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   t0, t1;
    logic [DVS_W-1:0] r0;
    logic             q0, q1;

    always_comb
    begin
        t0 = {rem_reg, work_reg[PAD_W-1]};
        q0 = (t0 >= {1'b0, divisor});
        r0 = q0 ? DVS_W'(t0 - {1'b0, divisor}) : t0[DVS_W-1:0];
        t1 = {r0, work_reg[PAD_W-2]};
        q1 = (t1 >= {1'b0, divisor});
        rem_next  = q1 ? DVS_W'(t1 - {1'b0, divisor}) : t1[DVS_W-1:0];
        work_next = {work_reg[PAD_W-3:0], q0, q1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= PAD_W'(dividend);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[DVD_W-1:0];

endmodule

// ===== src/tgtd_front.sv =====
`timescale 1ns / 1ps

// Scale a touch sample to pixels and locate its grid cell.
module tgtd_front
    import tgtd_pkg::*;
#(
    parameter int COLS    = 4,
    parameter int ROWS    = 2,
    parameter int RAW_MAX = 4095,
    localparam int NUM    = COLS * ROWS,
    localparam int IDX_W  = (NUM > 1) ? $clog2(NUM) : 1,
    localparam int ENT_W  = 1 + IDX_W + TIME_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_touched,
    input  logic [RAW_W-1:0]  in_raw_x,
    input  logic [RAW_W-1:0]  in_raw_y,
    input  logic [TIME_W-1:0] in_now,
    input  logic [SIZE_W-1:0] screen_width,
    input  logic [SIZE_W-1:0] screen_height,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ENT_W-1:0]  out_data
);

    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PROD_W = RAW_W + SIZE_W;

    // Scaling by reciprocal: floor(p/RAW_MAX) = (p*SM) >> (PROD_W+SL),
    // SM = ceil(2^(PROD_W+SL)/RAW_MAX), exact for every p below 2^PROD_W
    localparam int SL     = $clog2(RAW_MAX);
    localparam int SSH    = PROD_W + SL;
    localparam int SM_W   = PROD_W + 1;
    localparam int SMUL_W = PROD_W + SM_W;
    localparam int SQ_W   = SMUL_W - SSH;
    localparam logic [SM_W-1:0] SM =
        SM_W'(((64'd1 << SSH) + 64'(RAW_MAX) - 64'd1) / 64'(RAW_MAX));

    // Cell size by reciprocal: floor(s/d) = (s*m) >> (SIZE_W+l), m = ceil(2^(SIZE_W+l)/d)
    localparam int CL    = $clog2(COLS);
    localparam int RL    = $clog2(ROWS);
    localparam int CSH   = SIZE_W + CL;
    localparam int RSH   = SIZE_W + RL;
    localparam int CM_W  = CSH + 1;
    localparam int RM_W  = RSH + 1;
    localparam int CM    = ((2 ** CSH) + COLS - 1) / COLS;
    localparam int RM    = ((2 ** RSH) + ROWS - 1) / ROWS;

    localparam logic [2:0] F_IDLE      = 3'd0;
    localparam logic [2:0] F_SCALE_MUL = 3'd1;
    localparam logic [2:0] F_SCALE     = 3'd2;
    localparam logic [2:0] F_CELL_GO   = 3'd3;
    localparam logic [2:0] F_CELL      = 3'd4;
    localparam logic [2:0] F_PUSH      = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SIZE_W-1:0] px_reg, py_reg;
    logic [SIZE_W-1:0] cw_reg, ch_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [SIZE_W-1:0]      top_x, top_y;
    logic [SIZE_W+CM_W-1:0] cw_prod;
    logic [SIZE_W+RM_W-1:0] ch_prod;
    logic [SMUL_W-1:0]      sx_mul, sy_mul;
    logic [SIZE_W-1:0]      col_q, row_q;
    logic                   col_done, row_done;
    logic [SIZE_W-1:0]      px_clamp, py_clamp;
    logic                   cell_hit;
    logic [IDX_W-1:0]       cell_idx;

    assign top_x   = screen_width - SIZE_W'(1);
    assign top_y   = screen_height - SIZE_W'(1);
    assign cw_prod = (SIZE_W+CM_W)'(screen_width) * (SIZE_W+CM_W)'(CM);
    assign ch_prod = (SIZE_W+RM_W)'(screen_height) * (SIZE_W+RM_W)'(RM);
    assign sx_mul  = SMUL_W'(prod_x_reg) * SMUL_W'(SM);
    assign sy_mul  = SMUL_W'(prod_y_reg) * SMUL_W'(SM);

    // Track cell size from configuration; settles long before it is used.
    always_ff @(posedge clk)
    begin
        cw_reg <= cw_prod[CSH +: SIZE_W];
        ch_reg <= ch_prod[RSH +: SIZE_W];
    end

    tgtd_div #(.DVD_W(SIZE_W), .DVS_W(SIZE_W)) u_cell_col
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == F_CELL_GO),
        .dividend (px_reg),
        .divisor  (cw_reg),
        .done     (col_done),
        .quotient (col_q)
    );

    tgtd_div #(.DVD_W(SIZE_W), .DVS_W(SIZE_W)) u_cell_row
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == F_CELL_GO),
        .dividend (py_reg),
        .divisor  (ch_reg),
        .done     (row_done),
        .quotient (row_q)
    );

    always_comb
    begin
        // Clamp scaled value to size-1
        px_clamp = (PROD_W'(sx_reg) > PROD_W'(top_x)) ? top_x : SIZE_W'(sx_reg);
        py_clamp = (PROD_W'(sy_reg) > PROD_W'(top_y)) ? top_y : SIZE_W'(sy_reg);
        cell_hit = (col_q < SIZE_W'(COLS)) && (row_q < SIZE_W'(ROWS));
        cell_idx = IDX_W'(row_q[ROW_W-1:0]) * IDX_W'(COLS) + IDX_W'(col_q[COL_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                    state_next = in_touched ? F_SCALE_MUL : F_PUSH;
            end
            F_SCALE_MUL: state_next = F_SCALE;
            F_SCALE:
            begin
                if (cw_reg == '0 || ch_reg == '0)
                    state_next = F_PUSH;
                else
                    state_next = F_CELL_GO;
            end
            F_CELL_GO: state_next = F_CELL;
            F_CELL:
            begin
                if (col_done && row_done)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (out_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    prod_x_reg <= PROD_W'(in_raw_x) * PROD_W'(top_x);
                    prod_y_reg <= PROD_W'(in_raw_y) * PROD_W'(top_y);
                    now_reg    <= in_now;
                    hit_reg    <= 1'b0;
                    idx_reg    <= '0;
                end
            end
            F_SCALE_MUL:
            begin
                sx_reg <= sx_mul[SSH +: SQ_W];
                sy_reg <= sy_mul[SSH +: SQ_W];
            end
            F_SCALE:
            begin
                px_reg <= px_clamp;
                py_reg <= py_clamp;
            end
            F_CELL:
            begin
                hit_reg <= cell_hit;
                idx_reg <= cell_idx;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);
    assign out_data  = {hit_reg, idx_reg, now_reg};

endmodule

// ===== src/tgtd_queue.sv =====
`timescale 1ns / 1ps

// Small register FIFO between the locate and toggle stages.
module tgtd_queue
#(
    parameter int W     = 36,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== src/tgtd_back.sv =====
`timescale 1ns / 1ps

// Debounce a located press, flip the button and build the coil write.
module tgtd_back
    import tgtd_pkg::*;
#(
    parameter int COLS   = 4,
    parameter int ROWS   = 2,
    localparam int NUM   = COLS * ROWS,
    localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1,
    localparam int ENT_W = 1 + IDX_W + TIME_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ENT_W-1:0]  in_data,
    input  logic [DEB_W-1:0]  debounce_ms,
    input  logic [COIL_W-1:0] coil_base,
    input  logic [UNIT_W-1:0] slave_unit,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_toggled,
    output logic [BIDX_W-1:0] out_index,
    output logic              out_state,
    output logic [COIL_W-1:0] out_coil,
    output logic [UNIT_W-1:0] out_unit,
    output logic              out_newly_on
);

    logic              btn_reg  [NUM];
    logic [TIME_W-1:0] last_reg [NUM];

    logic              out_valid_reg;
    logic              toggled_reg;
    logic [BIDX_W-1:0] index_reg;
    logic              state_reg;
    logic [COIL_W-1:0] coil_reg;
    logic [UNIT_W-1:0] unit_reg;

    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] diff;
    logic              fire;
    logic              take;
    logic              flipped;

    assign {hit, idx, now} = in_data;
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        diff    = now - last_reg[idx];
        // Toggle only on a forward, long enough gap
        fire    = hit && !diff[TIME_W-1] && (diff > TIME_W'(debounce_ms));
        flipped = !btn_reg[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM; i++)
            begin
                btn_reg[i]  <= 1'b0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (take && fire)
            begin
                btn_reg[idx]  <= flipped;
                last_reg[idx] <= now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            toggled_reg <= fire;
            index_reg   <= fire ? BIDX_W'(idx) : '0;
            state_reg   <= fire && flipped;
            coil_reg    <= fire ? coil_base + COIL_W'(idx) : '0;
            unit_reg    <= fire ? slave_unit : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_toggled  = toggled_reg;
    assign out_index    = index_reg;
    assign out_state    = state_reg;
    assign out_coil     = coil_reg;
    assign out_unit     = unit_reg;
    assign out_newly_on = state_reg;

endmodule

// ===== src/touch_grid_toggle_debounce_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  touch sample: touched, raw X/Y, time stamp
// m_*       out  m_tvalid/m_tready  toggle report: button, state, coil, unit
// cfg_*     in   cfg_we             register write, no read-back
//
// A touched sample holds the locate stage from one accept to the next: the
// accept, a reciprocal multiply and clamp to scale X/Y, a start state, a
// pass of the cell dividers (11-bit dividend, two bits per cycle, then the
// done strobe) and a hand-over that waits while the queue is full.
// An untouched sample goes to the hand-over; zero-size cells skip the dividers.
// The toggle stage retires one request per cycle unless m_tready stalls it.
// A two-entry queue parts the stages, so a stalled m_tready holds only the
// toggle stage until the queue fills. Reset clears all button states and
// press times at once and loads the register defaults.
module touch_grid_toggle_debounce_unit
    import tgtd_pkg::*;
#(
    parameter int BUTTON_COLUMNS = 4,
    parameter int BUTTON_ROWS    = 2,
    parameter int RAW_MAX        = 4095
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    input  logic                 s_tuser,   // touched

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // button_index[2:0], new_state[3],
                                            // coil_address[19:4], unit_id_out[27:20],
                                            // newly_on[28], zero[31:29]
    output logic                 m_tuser,   // toggled

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NUM   = BUTTON_COLUMNS * BUTTON_ROWS;
    localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1;
    localparam int ENT_W = 1 + IDX_W + TIME_W;

    // Configuration registers
    logic [SIZE_W-1:0] screen_width_reg;
    logic [SIZE_W-1:0] screen_height_reg;
    logic [DEB_W-1:0]  debounce_ms_reg;
    logic [COIL_W-1:0] coil_base_reg;
    logic [UNIT_W-1:0] slave_unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            debounce_ms_reg   <= RST_DEBOUNCE_MS;
            coil_base_reg     <= RST_COIL_BASE;
            slave_unit_reg    <= RST_SLAVE_UNIT;
        end
        else if (cfg_we)
        begin
            // Drop writes to unknown indexes
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data[DEB_W-1:0];
                CFG_COIL_BASE:     coil_base_reg     <= cfg_data[COIL_W-1:0];
                CFG_SLAVE_UNIT:    slave_unit_reg    <= cfg_data[UNIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Locate stage -> queue -> toggle stage
    logic             loc_valid, loc_ready;
    logic [ENT_W-1:0] loc_data;
    logic             req_valid, req_ready;
    logic [ENT_W-1:0] req_data;

    logic              rep_toggled;
    logic [BIDX_W-1:0] rep_index;
    logic              rep_state;
    logic [COIL_W-1:0] rep_coil;
    logic [UNIT_W-1:0] rep_unit;
    logic              rep_newly_on;

    tgtd_front
    #(
        .COLS    (BUTTON_COLUMNS),
        .ROWS    (BUTTON_ROWS),
        .RAW_MAX (RAW_MAX)
    )
    u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_touched    (s_tuser),
        .in_raw_x      (s_tdata[11:0]),
        .in_raw_y      (s_tdata[23:12]),
        .in_now        (s_tdata[55:24]),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .out_valid     (loc_valid),
        .out_ready     (loc_ready),
        .out_data      (loc_data)
    );

    tgtd_queue #(.W(ENT_W), .DEPTH(2)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (loc_valid),
        .push_ready (loc_ready),
        .push_data  (loc_data),
        .pop_valid  (req_valid),
        .pop_ready  (req_ready),
        .pop_data   (req_data)
    );

    tgtd_back
    #(
        .COLS (BUTTON_COLUMNS),
        .ROWS (BUTTON_ROWS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req_valid),
        .in_ready     (req_ready),
        .in_data      (req_data),
        .debounce_ms  (debounce_ms_reg),
        .coil_base    (coil_base_reg),
        .slave_unit   (slave_unit_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_toggled  (rep_toggled),
        .out_index    (rep_index),
        .out_state    (rep_state),
        .out_coil     (rep_coil),
        .out_unit     (rep_unit),
        .out_newly_on (rep_newly_on)
    );

    // Pack the report, lowest field first
    assign m_tdata = {3'b000, rep_newly_on, rep_unit, rep_coil, rep_state, rep_index};
    assign m_tuser = rep_toggled;

endmodule

// ===== bench/tgtd_checker.sv =====
`timescale 1ns / 1ps

module tgtd_checker
    import tgtd_pkg::*;
#(
    parameter int GRID_COLS = 4,
    parameter int GRID_ROWS = 2,
    parameter int RAW_FULL  = 4095
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam int N_BUTTONS = GRID_COLS * GRID_ROWS;

    typedef struct packed {
        logic              toggled;
        logic [BIDX_W-1:0] button;
        logic              state;
        logic [COIL_W-1:0] coil;
        logic [UNIT_W-1:0] unit;
        logic              newly_on;
    } toggle_report_t;

    // m_tdata layout, top bits first
    typedef struct packed {
        logic [2:0]        pad;
        logic              newly_on;
        logic [UNIT_W-1:0] unit;
        logic [COIL_W-1:0] coil;
        logic              state;
        logic [BIDX_W-1:0] button;
    } report_word_t;

    logic [SIZE_W-1:0] width_px;
    logic [SIZE_W-1:0] height_px;
    logic [DEB_W-1:0]  debounce;
    logic [COIL_W-1:0] coil_base;
    logic [UNIT_W-1:0] unit_id;

    logic              btn_on        [N_BUTTONS];
    logic [TIME_W-1:0] btn_pressed_at[N_BUTTONS];

    toggle_report_t reports[$];
    int             mismatches;

    // Scale a raw reading to 0..size-1; size is at least the grid count here.
    function automatic longint unsigned to_pixel(logic [RAW_W-1:0] raw, logic [SIZE_W-1:0] size);
        longint unsigned top;
        longint unsigned px;
        top = longint'(size) - 1;
        px  = (longint'(raw) * top) / RAW_FULL;
        return (px > top) ? top : px;
    endfunction

    // Locate the touched cell, apply the debounce and flip the button.
    function automatic toggle_report_t press(logic touched, logic [RAW_W-1:0] rx,
                                             logic [RAW_W-1:0] ry, logic [TIME_W-1:0] stamp);
        toggle_report_t  r;
        longint unsigned cell_w;
        longint unsigned cell_h;
        longint unsigned col;
        longint unsigned row;
        int              idx;
        logic [TIME_W-1:0] since;
        r      = '0;
        cell_w = width_px / GRID_COLS;
        cell_h = height_px / GRID_ROWS;
        if (!touched || cell_w == 0 || cell_h == 0)
            return r;
        col = to_pixel(rx, width_px) / cell_w;
        row = to_pixel(ry, height_px) / cell_h;
        if (col >= GRID_COLS || row >= GRID_ROWS)
            return r;
        idx   = int'(row) * GRID_COLS + int'(col);
        since = stamp - btn_pressed_at[idx];
        if (since[TIME_W-1] || since <= debounce)
            return r;
        btn_on[idx]         = !btn_on[idx];
        btn_pressed_at[idx] = stamp;
        r.toggled  = 1'b1;
        r.button   = idx[BIDX_W-1:0];
        r.state    = btn_on[idx];
        r.coil     = coil_base + idx[COIL_W-1:0];
        r.unit     = unit_id;
        r.newly_on = btn_on[idx];
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        toggle_report_t want;
        report_word_t   word;
        if (!rst_n)
        begin
            width_px   = RST_SCREEN_WIDTH;
            height_px  = RST_SCREEN_HEIGHT;
            debounce   = RST_DEBOUNCE_MS;
            coil_base  = RST_COIL_BASE;
            unit_id    = RST_SLAVE_UNIT;
            for (int i = 0; i < N_BUTTONS; i++)
            begin
                btn_on[i]         = 1'b0;
                btn_pressed_at[i] = '0;
            end
            reports.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_px  = cfg_data[SIZE_W-1:0];
                    CFG_SCREEN_HEIGHT: height_px = cfg_data[SIZE_W-1:0];
                    CFG_DEBOUNCE_MS:   debounce  = cfg_data[DEB_W-1:0];
                    CFG_COIL_BASE:     coil_base = cfg_data[COIL_W-1:0];
                    CFG_SLAVE_UNIT:    unit_id   = cfg_data[UNIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                word = report_word_t'(m_tdata);
                if (reports.size() == 0)
                begin
                    $error("toggle report with none expected: tuser=%0b tdata=%0h",
                           m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = reports.pop_front();
                    check_field("toggled",      want.toggled,  m_tuser);
                    check_field("button_index", want.button,   word.button);
                    check_field("new_state",    want.state,    word.state);
                    check_field("coil_address", want.coil,     word.coil);
                    check_field("unit_id_out",  want.unit,     word.unit);
                    check_field("newly_on",     want.newly_on, word.newly_on);
                    check_field("tdata pad",    0,             word.pad);
                end
            end
            if (s_tvalid && s_tready)
                reports.push_back(press(s_tuser, s_tdata[RAW_W-1:0],
                                        s_tdata[2*RAW_W-1:RAW_W],
                                        s_tdata[2*RAW_W+TIME_W-1:2*RAW_W]));
            errors  <= mismatches;
            pending <= reports.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tgtd_pkg::*;

    localparam int GRID_COLS      = 4;
    localparam int GRID_ROWS      = 2;
    localparam int RAW_FULL       = 4095;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 125;
    // first index past the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_SLAVE_UNIT + 3'd1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    logic                 s_tuser   = 1'b0; // touched
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // button_index[2:0], new_state[3],
                                            // coil_address[19:4], unit_id_out[27:20],
                                            // newly_on[28], zero[31:29]
    logic                 m_tuser;          // toggled
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int errors;
    int pending;

    // Idle pressure on each side, in percent per input request or per receiver decision; zero turns it off.
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left;
    int quiet     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    touch_grid_toggle_debounce_unit #(
        .BUTTON_COLUMNS (GRID_COLS),
        .BUTTON_ROWS    (GRID_ROWS),
        .RAW_MAX        (RAW_FULL)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tgtd_checker #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .RAW_FULL  (RAW_FULL)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Receiver: drop m_tready in bursts at random, with stall_pct setting how often.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which no request moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[touch_grid_toggle_debounce_unit] ERROR");
                $finish;
            end
        end
    end

    // Offer one touch sample and hold it until the block takes it.
    // Optionally idle first; s_tvalid stays high between back-to-back requests.
    task automatic send_touch(input logic touched, input logic [RAW_W-1:0] rx,
                              input logic [RAW_W-1:0] ry, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 18);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= touched;
        s_tdata  <= {stamp, ry, rx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop sending and hold until every predicted report has come back.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write all five registers back to back, then poke an unmapped index.
    // Bits above each register's width carry noise; the block must drop them.
    task automatic program_regs(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic [DEB_W-1:0] deb, input logic [COIL_W-1:0] coil,
                                input logic [UNIT_W-1:0] unit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= (CFG_W'($urandom) & ~CFG_W'(16'h07FF)) | CFG_W'(w);
        @(posedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= (CFG_W'($urandom) & ~CFG_W'(16'h07FF)) | CFG_W'(h);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_MS;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= CFG_COIL_BASE;
        cfg_data  <= coil;
        @(posedge clk);
        cfg_index <= CFG_SLAVE_UNIT;
        cfg_data  <= (CFG_W'($urandom) & ~CFG_W'(16'h00FF)) | CFG_W'(unit);
        @(posedge clk);
        cfg_index <= CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2));
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [DEB_W-1:0]  deb;
        logic [RAW_W-1:0]  rx;
        logic [RAW_W-1:0]  ry;
        logic [TIME_W-1:0] clock_ms;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 320x240 screen, 80x120 cells, 200 ms debounce.
        send_touch(1'b0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);  // untouched, all ones
        send_touch(1'b1, 12'h000, 12'h000, 32'd0);          // no time since reset press
        send_touch(1'b1, 12'h000, 12'h000, 32'd200);        // exactly the debounce: held
        send_touch(1'b1, 12'h000, 12'h000, 32'd201);        // button 0 on
        send_touch(1'b1, 12'h000, 12'h000, 32'd401);        // bounce
        send_touch(1'b1, 12'h000, 12'h000, 32'd402);        // button 0 off
        send_touch(1'b1, 12'hFFF, 12'hFFF, 32'd1000);       // far corner, button 7
        send_touch(1'b1, 12'hFFF, 12'h000, 32'd1000);       // button 3
        send_touch(1'b1, 12'h000, 12'hFFF, 32'd1000);       // button 4
        send_touch(1'b1, 12'hFFF, 12'hFFF, 32'h8000_03E8);  // time difference goes negative
        send_touch(1'b1, 12'd1500, 12'h000, 32'hFFFF_FFFF); // one behind reset press
        send_touch(1'b1, 12'd1500, 12'h000, 32'h7FFF_FFFF); // largest positive difference
        send_touch(1'b1, 12'hAAA, 12'h555, 32'h7FFF_FFFF);
        send_touch(1'b1, 12'h555, 12'hAAA, 32'h7FFF_FFFF);
        drain_reports();

        // Screen not a multiple of the cell: the right and bottom edges hit nothing.
        // Zero debounce and a coil base that wraps past the top of the address space.
        program_regs(11'd322, 11'd243, 16'd0, 16'hFFFC, 8'hFF);
        send_touch(1'b1, 12'hFFF, 12'h000, 32'h9000_0000);
        send_touch(1'b1, 12'h000, 12'hFFF, 32'h9000_0000);
        send_touch(1'b1, 12'd4060, 12'd3000, 32'h9000_0000);
        send_touch(1'b1, 12'd4060, 12'd3000, 32'h9000_0000); // same instant: held
        send_touch(1'b1, 12'd4060, 12'd3000, 32'h9000_0001);
        drain_reports();

        // Cells of zero size: nothing can be hit.
        program_regs(11'd3, 11'd240, 16'd0, 16'd0, 8'd0);
        send_touch(1'b1, 12'h000, 12'h000, 32'hC000_0000);
        drain_reports();
        program_regs(11'd320, 11'd1, 16'd0, 16'd0, 8'd0);
        send_touch(1'b1, 12'h000, 12'h000, 32'hC000_0000);
        drain_reports();

        // Random phases; each one drains before its registers change.
        clock_ms = 32'hA000_0000;
        rx = '0;
        ry = '0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    w = 11'd1024; h = 11'd1024; deb = 16'd0;
                    program_regs(w, h, deb, 16'hFFFF, 8'hFF);
                    gap_pct = 20; stall_pct = 20;
                end
                1:
                begin
                    w = 11'd4; h = 11'd2; deb = 16'hFFFF;
                    program_regs(w, h, deb, 16'h0000, 8'h00);
                    gap_pct = 50; stall_pct = 50;
                end
                2:
                begin
                    w = 11'h7FF; h = 11'h7FF; deb = DEB_W'($urandom_range(0, 500));
                    program_regs(w, h, deb, COIL_W'($urandom), UNIT_W'($urandom));
                    gap_pct = 0; stall_pct = 30;
                end
                3:
                begin
                    w = SIZE_W'($urandom_range(4, 1024)); h = SIZE_W'($urandom_range(2, 1024));
                    deb = DEB_W'($urandom_range(0, 2000));
                    program_regs(w, h, deb, COIL_W'($urandom), UNIT_W'($urandom));
                    gap_pct = 30; stall_pct = 0;
                end
                4:
                begin
                    w = SIZE_W'($urandom_range(4, 40)); h = SIZE_W'($urandom_range(2, 20));
                    deb = DEB_W'($urandom_range(0, 50));
                    program_regs(w, h, deb, COIL_W'($urandom), UNIT_W'($urandom));
                    gap_pct = 10; stall_pct = 10;
                end
                default:
                begin
                    // final stretch runs flat out on both sides
                    w = RST_SCREEN_WIDTH; h = RST_SCREEN_HEIGHT; deb = RST_DEBOUNCE_MS;
                    program_regs(w, h, deb, COIL_W'($urandom), UNIT_W'($urandom));
                    gap_pct = 0; stall_pct = 0;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // keep hammering the same spot a third of the time to exercise the debounce
                if ($urandom_range(0, 2) != 0)
                begin
                    rx = RAW_W'($urandom);
                    ry = RAW_W'($urandom);
                end
                case ($urandom_range(0, 15))
                    0:       clock_ms = clock_ms + $urandom_range(0, deb / 4);
                    12:      clock_ms = $urandom;
                    13:      clock_ms = clock_ms - $urandom_range(1, 1000);
                    14:      clock_ms = clock_ms + 32'h7FFF_FFFF + $urandom_range(0, 2);
                    15:      clock_ms = clock_ms + deb + $urandom_range(0, 1);
                    default: clock_ms = clock_ms + $urandom_range(deb / 2, 2 * deb + 2);
                endcase
                send_touch($urandom_range(0, 9) != 0, rx, ry, clock_ms);
            end
            drain_reports();
        end

        // Let any stray late report surface before the verdict.
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[touch_grid_toggle_debounce_unit] OK");
        else
            $display("[touch_grid_toggle_debounce_unit] ERROR");
        $finish;
    end

endmodule
